### rtl/spq_pkg.sv
// Package for the sorted priority queue: field widths, codes and item types.
package spq_pkg;

    localparam int KEY_W     = 16;
    localparam int PAYLOAD_W = 32;
    localparam int COUNT_W   = 8;
    localparam int STATUS_W  = 2;

    // Opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                 opcode;
        logic [KEY_W-1:0]     sort_key;
        logic [PAYLOAD_W-1:0] payload;
    } spq_req_t;

    typedef struct packed {
        logic [KEY_W-1:0]     out_key;
        logic [PAYLOAD_W-1:0] out_payload;
        logic [STATUS_W-1:0]  status;
        logic [COUNT_W-1:0]   entry_count;
        logic                 is_empty;
        logic                 is_full;
    } spq_rsp_t;

    // One stored entry
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } spq_entry_t;

    // Command broadcast to every cell in the same cycle
    typedef struct packed {
        logic       insert;
        logic       remove;
        spq_entry_t entry;
    } spq_cmd_t;

endpackage

### rtl/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: cell chain, entry count and result register.
//
//  channel | valid     | stall     | item       | direction
//  --------+-----------+-----------+------------+----------
//  request | req_valid | req_stall | req (spq_req_t) | in
//  result  | rsp_valid | rsp_stall | rsp (spq_rsp_t) | out
//
// One item per cycle while req_stall is low: every cell compares and shifts in the
// same cycle, so the result appears in the cycle after the request is taken.
// Reset clears the entry count and the result valid; entry contents are left as is.
// req_stall is high while a result waits on a stalled result channel.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  spq_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output spq_rsp_t rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    spq_rsp_t         rsp_reg;
    spq_rsp_t         rsp_next;

    logic             take;
    logic             full_now;
    logic             empty_now;
    spq_cmd_t         cmd;

    logic       ge_w    [DEPTH];
    spq_entry_t entry_w [DEPTH];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign take      = req_valid && !req_stall;
    assign full_now  = (count_reg == CNT_W'(DEPTH));
    assign empty_now = (count_reg == '0);

    // Command to the chain
    always_comb
    begin
        cmd.insert        = take && (req.opcode == OP_INSERT) && !full_now;
        cmd.remove        = take && (req.opcode == OP_REMOVE) && !empty_now;
        cmd.entry.key     = req.sort_key;
        cmd.entry.payload = req.payload;
    end

    // Cell chain; cell 0 is the head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic       left_ge;
        spq_entry_t left_entry;
        spq_entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_ge    = 1'b1;
            assign left_entry = cmd.entry;
        end
        else
        begin : g_body
            assign left_ge    = ge_w[i-1];
            assign left_entry = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_entry = entry_w[i];
        end
        else
        begin : g_inner
            assign right_entry = entry_w[i+1];
        end

        spq_cell u_cell
        (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (CNT_W'(i) < count_reg),
            .left_ge     (left_ge),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .ge          (ge_w[i]),
            .entry       (entry_w[i])
        );
    end

    // Count and result
    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        if (take)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.out_key     = '0;
            rsp_next.out_payload = '0;
            rsp_next.status      = ST_OK;
            if (req.opcode == OP_INSERT)
            begin
                if (full_now)
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            else if (empty_now)
            begin
                rsp_next.status = ST_EMPTY;
            end
            else
            begin
                rsp_next.out_key     = entry_w[0].key;
                rsp_next.out_payload = entry_w[0].payload;
            end
            rsp_next.entry_count = COUNT_W'(count_next);
            rsp_next.is_empty    = (count_next == '0);
            rsp_next.is_full     = (count_next == CNT_W'(DEPTH));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/spq_cell.sv
// One storage cell of the sorted queue chain: holds one entry, shifts with its neighbors.
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  spq_cmd_t   cmd,
    input  logic       occupied,
    input  logic       left_ge,
    input  spq_entry_t left_entry,
    input  spq_entry_t right_entry,
    output logic       ge,
    output spq_entry_t entry
);

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // This cell keeps its entry on insert when it holds a key not below the new one
    assign ge    = occupied && (entry_reg.key >= cmd.entry.key);
    assign entry = entry_reg;

    // Insert: first empty or smaller slot takes new entry, later slots take left one.
    // Remove: every slot takes the right neighbor's entry; the tail keeps its own.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert && !ge)
        begin
            entry_next = left_ge ? cmd.entry : left_entry;
        end
        else if (cmd.remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
